>>> rtl/core/chsd_pkg.sv
// Shared types and constants of the canonical Huffman stream decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package chsd_pkg;

  localparam int MAX_CODE_LEN = 16;
  localparam int MAX_SYMBOLS  = 256;

  // A size byte of zero stands for this alphabet size.
  localparam logic [8:0] SIZE_ZERO_MEANS = 9'h100;
  // The running symbol position saturates at this value.
  localparam logic [8:0] POS_SAT = 9'd511;

  localparam int CL_W   = $clog2(MAX_CODE_LEN + 1);
  localparam int CNT_AW = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
  localparam int SYM_AW = $clog2(MAX_SYMBOLS);
  localparam int ACC_W  = MAX_CODE_LEN + 1;
  // First code can grow well past the code bits when counts oversubscribe.
  localparam int FC_W   = MAX_CODE_LEN + 10;

  typedef enum logic [1:0] {
    PH_SIZE   = 2'd0,
    PH_COUNT  = 2'd1,
    PH_SYMS   = 2'd2,
    PH_DECODE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       bad_code;
    logic       run_end;
  } out_item_t;

  typedef struct packed {
    logic header;  // process the request on the input port as a header byte
    logic load;    // latch a code byte for bit-serial decoding
    logic step;    // decode one code bit
    logic flush;   // close the byte: push any held result as the run end
  } chsd_cmd_t;

  typedef struct packed {
    logic decoding;  // header is complete, bytes carry code bits
    logic emit;      // the current bit completes a result
    logic pend_v;    // a result is held back until its successor is known
    logic out_free;  // the output register can take a result this cycle
    logic last_bit;  // the current bit is the last of the byte
  } chsd_stat_t;

endpackage

>>> rtl/core/canonical_huffman_stream_decoder.sv
// Top level of the canonical Huffman stream decoder.
// Instantiates chsd_ctrl and chsd_dp; uses chsd_pkg for types and constants.
//
// Usage: bytes arrive on the in_ channel (valid/ready). Each stream opens with
// a header: a size byte (zero means 256 symbols), one count byte per code
// length starting at length one until the counts reach the size (at most 16),
// then the symbols in canonical order. Every later byte carries eight code
// bits, MSB first. Each decoded symbol leaves on the out_ channel as one
// request; bad_code marks a code that found no symbol, and run_end marks the
// last request produced by an input byte. A byte with final_byte set is
// handled normally, then any partial code is dropped and a new header begins.
//
// Timing: a header byte is taken and the block stays ready for the next byte.
// A code byte is accepted, then decoded in eight bit steps (each one a
// subtract-compare against the first code of the current length), then closed.
// The symbol memory is read with registered data, so each symbol is held back
// and leaves once its successor, or the byte end, is known. A stalled
// receiver holds the output register; the bit steps then wait only when a
// second result would have to pass it.
// Reset empties the result path and returns to the size byte with all code
// counts zero; the symbol memory is not cleared and needs no sweep.
module canonical_huffman_stream_decoder import chsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  chsd_cmd_t  cmd;
  chsd_stat_t stat;

  chsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  chsd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .out_ready (out_ready),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // An invalid code always carries symbol zero.
  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.bad_code) |-> (out_item.symbol == 8'd0))
    else $error("bad_code result with nonzero symbol");

  // The controller issues at most one command per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.header, cmd.load, cmd.step, cmd.flush}))
    else $error("more than one datapath command in a cycle");

  // A code byte keeps the input closed while its bits are decoded.
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && stat.decoding) |=> !in_ready)
    else $error("input reopened right after a code byte");

  // A flush never leaves a result held back.
  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> !stat.pend_v)
    else $error("held result survived the end of a byte");

endmodule

>>> rtl/core/chsd_ctrl.sv
// Controller of the canonical Huffman stream decoder: sequences byte intake,
// the eight bit steps of a code byte and the closing flush. Uses chsd_pkg.
module chsd_ctrl import chsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  chsd_stat_t stat,
  output chsd_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_BIT   = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   stall;

  // A new result may only be made when the held one can move on.
  assign stall = stat.emit && stat.pend_v && !stat.out_free;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (stat.decoding) begin
            cmd.load  = 1'b1;
            state_nxt = S_BIT;
          end else begin
            cmd.header = 1'b1;
          end
        end
      end
      S_BIT: begin
        if (!stall) begin
          cmd.step = 1'b1;
          if (stat.last_bit) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!stat.pend_v || stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/chsd_dp.sv
// Datapath of the canonical Huffman stream decoder: header registers, code
// count table, symbol memory, bit-serial code matcher and result registers.
// Uses chsd_pkg; driven by chsd_ctrl commands.
module chsd_dp import chsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  chsd_cmd_t  cmd,
  input  logic       out_ready,
  output chsd_stat_t stat,
  output logic       out_valid,
  output out_item_t  out_item
);

  phase_t                phase_r, phase_nxt;
  logic [8:0]            asize_r, asize_nxt;
  logic [8:0]            hprog_r, hprog_nxt;
  logic [CL_W-1:0]       cidx_r, cidx_nxt;
  logic [7:0]            counts_r [MAX_CODE_LEN];
  logic [7:0]            counts_nxt [MAX_CODE_LEN];
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [FC_W-1:0]       fc_r, fc_nxt;
  logic [8:0]            pos_r, pos_nxt;
  logic [CL_W-1:0]       clen_r, clen_nxt;
  logic [7:0]            byte_r, byte_nxt;
  logic [2:0]            bitcnt_r, bitcnt_nxt;
  logic                  last_r, last_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic                  pend_bad_r, pend_bad_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;
  logic [7:0]            rd_r;
  logic [7:0]            sym_mem [MAX_SYMBOLS];

  logic [7:0]            cnt;
  logic [ACC_W-1:0]      acc_sh;
  logic [FC_W-1:0]       fc_sh;
  logic [FC_W-1:0]       diff;
  logic                  hit;
  logic [9:0]            idx;
  logic                  good;
  logic [9:0]            pos_sum;
  logic [CL_W-1:0]       clen_inc;
  logic                  timeout;
  logic                  emit;
  logic                  push;
  logic                  rd_en;
  logic                  sym_we;
  logic [8:0]            size_val;
  logic [9:0]            hp_sum;

  // One bit of the canonical match: shift in the bit, compare against the
  // first code of the current length.
  always_comb begin
    cnt      = (clen_r < CL_W'(MAX_CODE_LEN)) ? counts_r[clen_r[CNT_AW-1:0]] : 8'd0;
    acc_sh   = {acc_r[ACC_W-2:0], byte_r[7]};
    fc_sh    = {fc_r[FC_W-2:0], 1'b0};
    diff     = FC_W'(acc_sh) - fc_sh;
    hit      = (FC_W'(acc_sh) >= fc_sh) && (diff < FC_W'(cnt));
    idx      = {1'b0, pos_r} + {2'b00, diff[7:0]};
    good     = idx < {1'b0, asize_r};
    pos_sum  = {1'b0, pos_r} + {2'b00, cnt};
    clen_inc = clen_r + CL_W'(1);
    timeout  = !hit && (clen_inc >= CL_W'(MAX_CODE_LEN));
    emit     = hit || timeout;
  end

  assign rd_en  = cmd.step && hit && good;
  assign push   = pend_v_r && ((cmd.step && emit) || cmd.flush);
  assign sym_we = cmd.header && (phase_r == PH_SYMS) && (hprog_r < 9'(MAX_SYMBOLS));

  always_comb begin
    phase_nxt    = phase_r;
    asize_nxt    = asize_r;
    hprog_nxt    = hprog_r;
    cidx_nxt     = cidx_r;
    counts_nxt   = counts_r;
    acc_nxt      = acc_r;
    fc_nxt       = fc_r;
    pos_nxt      = pos_r;
    clen_nxt     = clen_r;
    byte_nxt     = byte_r;
    bitcnt_nxt   = bitcnt_r;
    last_nxt     = last_r;
    pend_v_nxt   = pend_v_r;
    pend_bad_nxt = pend_bad_r;
    size_val     = 9'd0;
    hp_sum       = 10'd0;

    if (cmd.header) begin
      unique case (phase_r)
        PH_SIZE: begin
          size_val = (in_item.data_byte == 8'd0) ? SIZE_ZERO_MEANS
                                                 : {1'b0, in_item.data_byte};
          if (size_val > 9'(MAX_SYMBOLS)) begin
            size_val = 9'(MAX_SYMBOLS);
          end
          asize_nxt = size_val;
          for (int i = 0; i < MAX_CODE_LEN; i++) begin
            counts_nxt[i] = 8'd0;
          end
          hprog_nxt = 9'd0;
          cidx_nxt  = '0;
          phase_nxt = PH_COUNT;
        end
        PH_COUNT: begin
          if (cidx_r < CL_W'(MAX_CODE_LEN)) begin
            counts_nxt[cidx_r[CNT_AW-1:0]] = in_item.data_byte;
          end
          cidx_nxt = cidx_r + CL_W'(1);
          hp_sum   = {1'b0, hprog_r} + {2'b00, in_item.data_byte};
          if (hp_sum >= {1'b0, asize_r} || cidx_nxt >= CL_W'(MAX_CODE_LEN)) begin
            hprog_nxt = 9'd0;
            phase_nxt = PH_SYMS;
          end else begin
            hprog_nxt = hp_sum[8:0];
          end
        end
        PH_SYMS: begin
          hprog_nxt = hprog_r + 9'd1;
          if (hprog_nxt >= asize_r) begin
            phase_nxt = PH_DECODE;
            acc_nxt   = ACC_W'(1);
            fc_nxt    = FC_W'(1);
            pos_nxt   = 9'd0;
            clen_nxt  = '0;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    if (cmd.load) begin
      byte_nxt   = in_item.data_byte;
      last_nxt   = in_item.final_byte;
      bitcnt_nxt = 3'd0;
    end

    if (cmd.step) begin
      byte_nxt   = {byte_r[6:0], 1'b0};
      bitcnt_nxt = bitcnt_r + 3'd1;
      if (emit) begin
        pend_v_nxt   = 1'b1;
        pend_bad_nxt = !(hit && good);
        acc_nxt      = ACC_W'(1);
        fc_nxt       = FC_W'(1);
        pos_nxt      = 9'd0;
        clen_nxt     = '0;
      end else begin
        acc_nxt  = acc_sh;
        fc_nxt   = fc_sh + FC_W'(cnt);
        pos_nxt  = (pos_sum > {1'b0, POS_SAT}) ? POS_SAT : pos_sum[8:0];
        clen_nxt = clen_inc;
      end
    end

    if (cmd.flush) begin
      pend_v_nxt = 1'b0;
    end

    // The last byte of a stream drops any partial code and rearms the header.
    if ((cmd.header && in_item.final_byte) || (cmd.flush && last_r)) begin
      phase_nxt = PH_SIZE;
      hprog_nxt = 9'd0;
      cidx_nxt  = '0;
      acc_nxt   = ACC_W'(1);
      fc_nxt    = FC_W'(1);
      pos_nxt   = 9'd0;
      clen_nxt  = '0;
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_nxt.symbol   = pend_bad_r ? 8'd0 : rd_r;
      out_nxt.bad_code = pend_bad_r;
      out_nxt.run_end  = cmd.flush;
      out_valid_nxt    = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIZE;
      asize_r     <= 9'd0;
      hprog_r     <= 9'd0;
      cidx_r      <= '0;
      acc_r       <= ACC_W'(1);
      fc_r        <= FC_W'(1);
      pos_r       <= 9'd0;
      clen_r      <= '0;
      bitcnt_r    <= 3'd0;
      last_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
        counts_r[i] <= 8'd0;
      end
    end else begin
      phase_r     <= phase_nxt;
      asize_r     <= asize_nxt;
      hprog_r     <= hprog_nxt;
      cidx_r      <= cidx_nxt;
      acc_r       <= acc_nxt;
      fc_r        <= fc_nxt;
      pos_r       <= pos_nxt;
      clen_r      <= clen_nxt;
      bitcnt_r    <= bitcnt_nxt;
      last_r      <= last_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      counts_r    <= counts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    pend_bad_r <= pend_bad_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_mem[hprog_r[SYM_AW-1:0]] <= in_item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= sym_mem[idx[SYM_AW-1:0]];
    end
  end

  always_comb begin
    stat.decoding = (phase_r == PH_DECODE);
    stat.emit     = emit;
    stat.pend_v   = pend_v_r;
    stat.out_free = !out_valid_r || out_ready;
    stat.last_bit = (bitcnt_r == 3'd7);
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
